/* hdl/spl_pkg.sv */
// ----------------------------------------------------------------------------
// spl_pkg: shared types and codes of the sorted priority list
// Operation and status codes, the stored entry and the request/result items.
// ----------------------------------------------------------------------------
package spl_pkg;

    localparam logic [3:0] OP_INSERT     = 4'd0;
    localparam logic [3:0] OP_REMOVE_AT  = 4'd1;
    localparam logic [3:0] OP_CLEAR      = 4'd2;
    localparam logic [3:0] OP_CUR_FIRST  = 4'd3;
    localparam logic [3:0] OP_CUR_NEXT   = 4'd4;
    localparam logic [3:0] OP_CUR_PREV   = 4'd5;
    localparam logic [3:0] OP_READ_CUR   = 4'd6;
    localparam logic [3:0] OP_READ_FIRST = 4'd7;
    localparam logic [3:0] OP_READ_LAST  = 4'd8;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_ERR  = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic [31:0] prio;
        logic [15:0] elem;
        logic [15:0] leaf;
    } t_entry;

    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] prio;
        logic [15:0] elem;
        logic [15:0] leaf;
        logic [5:0]  pos;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  count;
        logic        item_valid;
        logic [31:0] item_prio;
        logic [15:0] item_elem;
        logic [15:0] item_leaf;
        logic [5:0]  cursor;
    } t_result;

endpackage

/* hdl/sorted_priority_list.sv */
// Sorted priority list: holds up to CAPACITY entries in descending priority
// order in a single-port-write, single-port-read memory. One request gives
// one response. Every request passes through acceptance, decode and a done
// state that presents its response to the output register; clear, cursor
// moves and reads need nothing more. An insert moves each entry of lower
// priority up by one and then writes the new entry; a removal pulls each
// entry behind the removed position down by one. Those moves go one
// entry per cycle through the memory's read and write ports. The input is
// not ready while a request is in work; a finished response waits in the
// output register, so the next request can be taken meanwhile.
// ----------------------------------------------------------------------------
// sorted_priority_list: top level
// Stream ports, request unpacking, response output register and checks.
// ----------------------------------------------------------------------------
module sorted_priority_list #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] priority_req, [47:32] element_handle, [63:48] leaf_handle,
    // [69:64] position, [71:70] zero
    input  logic [71:0] s_axis_tdata,
    // [3:0] operation
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [6:0] entry_count_out, [38:7] item_priority, [54:39] item_element,
    // [70:55] item_leaf, [76:71] cursor_position, [79:77] zero
    output logic [79:0] m_axis_tdata,
    // [1:0] status, [2] item_valid
    output logic [2:0]  m_axis_tuser
);
    import spl_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    t_req          w_req;
    t_result       w_res;
    logic          w_res_valid;
    logic          w_out_free;
    logic          w_mem_we;
    logic [AW-1:0] w_mem_waddr;
    t_entry        w_mem_wdata;
    logic          w_mem_re;
    logic [AW-1:0] w_mem_raddr;
    t_entry        w_mem_rdata;

    logic          r_out_valid;
    t_result       r_out;

    assign w_req = '{op:   s_axis_tuser,
                     prio: s_axis_tdata[31:0],
                     elem: s_axis_tdata[47:32],
                     leaf: s_axis_tdata[63:48],
                     pos:  s_axis_tdata[69:64]};

    spl_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req       (w_req),
        .o_req_ready (s_axis_tready),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_out_free),
        .o_res       (w_res),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_re    (w_mem_re),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    spl_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // the output register takes a new response when empty or being drained
    assign w_out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_out_free) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.cursor, r_out.item_leaf, r_out.item_elem,
                            r_out.item_prio, r_out.count};
    assign m_axis_tuser  = {r_out.item_valid, r_out.status};

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a request was taken");

    a_res_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid && w_out_free |=> m_axis_tvalid)
        else $error("finished response did not reach the output register");

    a_item_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == STAT_OK)
        else $error("entry returned with a failing status");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] == STAT_FULL
        |-> m_axis_tdata[6:0] == 7'(CAPACITY))
        else $error("full status with the list not at capacity");

endmodule

/* hdl/spl_mem.sv */
// ----------------------------------------------------------------------------
// spl_mem: entry store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spl_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  spl_pkg::t_entry i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output spl_pkg::t_entry o_rdata
);
    import spl_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/spl_seq.sv */
// ----------------------------------------------------------------------------
// spl_seq: list sequencer
// Decodes one request, walks the store one entry per cycle to open or close
// a gap, keeps count and cursor, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module spl_seq #(
    parameter int CAPACITY = 64,
    parameter int AW       = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  spl_pkg::t_req    i_req,
    output logic             o_req_ready,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output spl_pkg::t_result o_res,
    output logic             o_mem_we,
    output logic [AW-1:0]    o_mem_waddr,
    output spl_pkg::t_entry  o_mem_wdata,
    output logic             o_mem_re,
    output logic [AW-1:0]    o_mem_raddr,
    input  spl_pkg::t_entry  i_mem_rdata
);
    import spl_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = (CW > 7) ? CW : 7;
    localparam logic [KW-1:0] CAP_K = KW'(CAPACITY);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_INS      = 3'd2;
    localparam logic [2:0] S_INS_LAST = 3'd3;
    localparam logic [2:0] S_RM       = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    logic [2:0]    r_state, n_state;
    t_req          r_req, n_req;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_cur, n_cur;
    logic          r_cur_valid, n_cur_valid;
    logic [AW-1:0] r_slot, n_slot;
    logic [1:0]    r_status, n_status;
    logic          r_item_valid, n_item_valid;

    logic [KW-1:0] count_k, pos_k, cur_k, slot_k;
    t_entry        new_entry;

    assign count_k   = KW'(r_count);
    assign pos_k     = KW'(r_req.pos);
    assign cur_k     = KW'(r_cur);
    assign slot_k    = KW'(r_slot);
    assign new_entry = '{prio: r_req.prio, elem: r_req.elem, leaf: r_req.leaf};

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_count      = r_count;
        n_cur        = r_cur;
        n_cur_valid  = r_cur_valid;
        n_slot       = r_slot;
        n_status     = r_status;
        n_item_valid = r_item_valid;
        o_mem_we     = 1'b0;
        o_mem_waddr  = r_slot;
        o_mem_wdata  = new_entry;
        o_mem_re     = 1'b0;
        o_mem_raddr  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req   = i_req;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status     = STAT_ERR;
                n_item_valid = 1'b0;
                n_state      = S_DONE;
                unique case (r_req.op)
                    OP_INSERT: begin
                        if (r_req.elem == 16'd0 && r_req.leaf == 16'd0) begin
                            n_status = STAT_ERR;
                        end else if (count_k >= CAP_K) begin
                            n_status = STAT_FULL;
                        end else begin
                            n_status = STAT_OK;
                            n_slot   = r_count[AW-1:0];
                            if (r_count == '0) begin
                                n_state = S_INS_LAST;
                            end else begin
                                o_mem_re    = 1'b1;
                                o_mem_raddr = AW'(count_k - KW'(1));
                                n_state     = S_INS;
                            end
                        end
                    end
                    OP_REMOVE_AT: begin
                        if (pos_k < count_k) begin
                            n_status = STAT_OK;
                            n_slot   = pos_k[AW-1:0];
                            if (r_cur_valid) begin
                                if (cur_k == pos_k) begin
                                    n_cur_valid = 1'b0;
                                end else if (cur_k > pos_k) begin
                                    n_cur = r_cur - AW'(1);
                                end
                            end
                            if (pos_k + KW'(1) < count_k) begin
                                o_mem_re    = 1'b1;
                                o_mem_raddr = AW'(pos_k + KW'(1));
                                n_state     = S_RM;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                    end
                    OP_CLEAR: begin
                        if (r_count != '0) begin
                            n_status = STAT_OK;
                        end
                        n_count     = '0;
                        n_cur       = '0;
                        n_cur_valid = 1'b0;
                    end
                    OP_CUR_FIRST: begin
                        if (r_count != '0) begin
                            n_cur       = '0;
                            n_cur_valid = 1'b1;
                            n_status    = STAT_OK;
                        end
                    end
                    OP_CUR_NEXT: begin
                        if (r_cur_valid && (cur_k + KW'(1) < count_k)) begin
                            n_cur    = r_cur + AW'(1);
                            n_status = STAT_OK;
                        end
                    end
                    OP_CUR_PREV: begin
                        if (r_cur_valid && r_cur != '0) begin
                            n_cur    = r_cur - AW'(1);
                            n_status = STAT_OK;
                        end
                    end
                    OP_READ_CUR: begin
                        if (r_cur_valid && cur_k < count_k) begin
                            o_mem_re     = 1'b1;
                            o_mem_raddr  = r_cur;
                            n_item_valid = 1'b1;
                            n_status     = STAT_OK;
                        end
                    end
                    OP_READ_FIRST: begin
                        if (r_count != '0) begin
                            o_mem_re     = 1'b1;
                            o_mem_raddr  = '0;
                            n_item_valid = 1'b1;
                            n_status     = STAT_OK;
                        end
                    end
                    OP_READ_LAST: begin
                        if (r_count != '0) begin
                            o_mem_re     = 1'b1;
                            o_mem_raddr  = AW'(count_k - KW'(1));
                            n_item_valid = 1'b1;
                            n_status     = STAT_OK;
                        end
                    end
                    default: begin
                        n_status = STAT_ERR;
                    end
                endcase
            end
            S_INS: begin
                // read data is the entry just below the gap at r_slot
                o_mem_we = 1'b1;
                if (i_mem_rdata.prio < r_req.prio) begin
                    o_mem_wdata = i_mem_rdata;
                    n_slot      = r_slot - AW'(1);
                    if (r_slot == AW'(1)) begin
                        n_state = S_INS_LAST;
                    end else begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = AW'(slot_k - KW'(2));
                    end
                end else begin
                    o_mem_wdata = new_entry;
                    n_count     = r_count + CW'(1);
                    if (r_cur_valid && r_cur >= r_slot) begin
                        n_cur = r_cur + AW'(1);
                    end
                    n_state = S_DONE;
                end
            end
            S_INS_LAST: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = '0;
                o_mem_wdata = new_entry;
                n_count     = r_count + CW'(1);
                if (r_cur_valid) begin
                    n_cur = r_cur + AW'(1);
                end
                n_state = S_DONE;
            end
            S_RM: begin
                // pull the next entry down over the gap
                o_mem_we    = 1'b1;
                o_mem_wdata = i_mem_rdata;
                n_slot      = r_slot + AW'(1);
                if (slot_k + KW'(2) < count_k) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = AW'(slot_k + KW'(2));
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cur       <= '0;
            r_cur_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cur       <= n_cur;
            r_cur_valid <= n_cur_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_slot       <= n_slot;
        r_status     <= n_status;
        r_item_valid <= n_item_valid;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res.status     = r_status;
        o_res.count      = count_k[6:0];
        o_res.item_valid = r_item_valid;
        o_res.item_prio  = r_item_valid ? i_mem_rdata.prio : 32'd0;
        o_res.item_elem  = r_item_valid ? i_mem_rdata.elem : 16'd0;
        o_res.item_leaf  = r_item_valid ? i_mem_rdata.leaf : 16'd0;
        o_res.cursor     = r_cur_valid ? cur_k[5:0] : 6'd0;
    end

endmodule
